// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the alarm clock block. Each macro builds one
// concurrent assertion that is sampled on the rising clock edge and held off
// while the synchronous reset is asserted.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ACW_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ACW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/acw_pkg.sv =====
// ----------------------------------------------------------------------------
// acw_pkg
// Types, operation codes, mode codes and time constants shared by the
// alarm clock modules and its channel interfaces.
// ----------------------------------------------------------------------------
package acw_pkg;

    // Operation codes carried by an input transaction.
    localparam logic [1:0] OP_TICK       = 2'd0;
    localparam logic [1:0] OP_CTRL       = 2'd1;
    localparam logic [1:0] OP_LOAD_CLOCK = 2'd2;
    localparam logic [1:0] OP_LOAD_ALARM = 2'd3;

    // Operating modes.
    localparam logic [2:0] MODE_DISP      = 3'd0;
    localparam logic [2:0] MODE_SET_TIME  = 3'd1;
    localparam logic [2:0] MODE_ALARM     = 3'd2;
    localparam logic [2:0] MODE_SNOOZE    = 3'd3;
    localparam logic [2:0] MODE_SET_ALARM = 3'd4;

    // Button patterns seen by a control pass.
    localparam logic [2:0] BTN_SET_TIME  = 3'b001;
    localparam logic [2:0] BTN_SET_ALARM = 3'b010;
    localparam logic [2:0] BTN_ALARM     = 3'b100;

    // Time limits and offsets.
    localparam logic [5:0] SECS_PER_MIN  = 6'd60;
    localparam logic [5:0] MINS_PER_HOUR = 6'd60;
    localparam logic [5:0] SNOOZE_SECS   = 6'd10;
    localparam int         BEEP_BITS     = 5;

    // Reset values.
    localparam logic [4:0] HOUR_MODE_RST = 5'd12;
    localparam logic [4:0] CLK_HRS_RST   = 5'd12;
    localparam logic [5:0] CLK_MINS_RST  = 6'd1;

    // One time of day.
    typedef struct packed {
        logic [4:0] hrs;
        logic [5:0] mins;
        logic [5:0] secs;
    } t_hms;

    // Clock time together with the AM/PM flag.
    typedef struct packed {
        t_hms time_of_day;
        logic half_day;
    } t_clk_state;

    // Outcome of a control pass.
    typedef struct packed {
        logic [2:0] mode;
        t_hms       snooze;
        logic       cleared;
    } t_ctrl_res;

    // Input transaction payload.
    typedef struct packed {
        logic [1:0] op;
        logic [2:0] buttons;
        logic [4:0] load_hours;
        logic [5:0] load_minutes;
        logic [5:0] load_seconds;
    } t_acw_in;

    // Result transaction payload.
    typedef struct packed {
        logic [2:0] mode;
        logic       beeper_on;
        logic [4:0] shown_hours;
        logic [5:0] shown_minutes;
        logic [5:0] clock_seconds;
        logic       pm_flag;
        logic       buttons_cleared;
    } t_acw_out;

endpackage

// ===== src/acw_in_if.sv =====
// ----------------------------------------------------------------------------
// acw_in_if
// Valid/ready channel that carries input transactions to the alarm clock.
// ----------------------------------------------------------------------------
interface acw_in_if;
    import acw_pkg::*;

    logic    valid;
    logic    ready;
    t_acw_in data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== src/acw_out_if.sv =====
// ----------------------------------------------------------------------------
// acw_out_if
// Valid/ready channel that carries result transactions from the alarm clock.
// ----------------------------------------------------------------------------
interface acw_out_if;
    import acw_pkg::*;

    logic     valid;
    logic     ready;
    t_acw_out data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== src/acw_tick.sv =====
// ----------------------------------------------------------------------------
// acw_tick
// Next-state logic for one oscillator tick: prescaler, seconds, minutes and
// hours with carries, hour wrap by the hour mode, and the beep phase toggle.
// ----------------------------------------------------------------------------
module acw_tick #(
    parameter int TICKS_PER_SECOND = 128
) (
    input  logic [$clog2(TICKS_PER_SECOND)-1:0] i_presc,
    input  acw_pkg::t_clk_state                 i_cur,
    input  logic [4:0]                          i_hour_mode,
    output logic [$clog2(TICKS_PER_SECOND)-1:0] o_presc,
    output acw_pkg::t_clk_state                 o_nxt,
    output logic                                o_beep_toggle
);
    import acw_pkg::*;

    localparam int PW = $clog2(TICKS_PER_SECOND);
    localparam int BW = (PW < BEEP_BITS) ? PW : BEEP_BITS;

    logic [PW:0] w_presc_inc;
    logic        w_sec_step;
    logic [5:0]  w_secs;
    logic [5:0]  w_mins;
    logic [4:0]  w_hrs;
    logic        w_min_step;
    logic        w_hr_step;
    logic        w_wrap;

    // Prescaler: one second every TICKS_PER_SECOND ticks.
    assign w_presc_inc = {1'b0, i_presc} + (PW + 1)'(1);
    assign w_sec_step  = (w_presc_inc >= (PW + 1)'(TICKS_PER_SECOND));
    assign o_presc     = w_sec_step ? '0 : w_presc_inc[PW-1:0];

    // Seconds, minutes and hours; out-of-range loaded values normalize here.
    always_comb begin
        w_secs = w_sec_step ? (i_cur.time_of_day.secs + 6'd1) : i_cur.time_of_day.secs;
        w_min_step = (w_secs >= SECS_PER_MIN);
        if (w_min_step) begin
            w_secs = '0;
        end
        w_mins = w_min_step ? (i_cur.time_of_day.mins + 6'd1) : i_cur.time_of_day.mins;
        w_hr_step = (w_mins >= MINS_PER_HOUR);
        if (w_hr_step) begin
            w_mins = '0;
        end
        w_hrs  = w_hr_step ? (i_cur.time_of_day.hrs + 5'd1) : i_cur.time_of_day.hrs;
        w_wrap = (w_hrs > i_hour_mode);
        if (w_wrap) begin
            w_hrs = w_hrs - i_hour_mode;
        end
    end

    assign o_nxt.time_of_day.secs = w_secs;
    assign o_nxt.time_of_day.mins = w_mins;
    assign o_nxt.time_of_day.hrs  = w_hrs;
    assign o_nxt.half_day         = i_cur.half_day ^ w_wrap;

    // The beep phase flips every 32 prescaler counts.
    assign o_beep_toggle = (o_presc[BW-1:0] == '0);
endmodule

// ===== src/acw_ctrl.sv =====
// ----------------------------------------------------------------------------
// acw_ctrl
// Button rules of a control pass: mode changes, snooze time, latch clear
// request, and the alarm and snooze time match against the clock.
// ----------------------------------------------------------------------------
module acw_ctrl (
    input  logic [2:0]          i_mode,
    input  logic [2:0]          i_buttons,
    input  acw_pkg::t_hms       i_clock,
    input  acw_pkg::t_hms       i_alarm,
    input  acw_pkg::t_hms       i_snooze,
    input  logic [4:0]          i_hour_mode,
    output acw_pkg::t_ctrl_res  o_res
);
    import acw_pkg::*;

    logic [6:0] w_s_sum;
    logic [6:0] w_m_sum;
    logic       w_s_carry;
    logic       w_m_carry;
    logic [4:0] w_h_sum;
    t_hms       w_snooze_clk;
    logic [2:0] w_mode;
    t_hms       w_snooze;
    logic       w_cleared;
    logic       w_match;

    // Snooze time: clock plus ten seconds, carried into minutes and hours.
    always_comb begin
        w_s_sum   = {1'b0, i_clock.secs} + {1'b0, SNOOZE_SECS};
        w_s_carry = (w_s_sum >= {1'b0, SECS_PER_MIN});
        if (w_s_carry) begin
            w_s_sum = w_s_sum - {1'b0, SECS_PER_MIN};
        end
        w_m_sum   = {1'b0, i_clock.mins} + {6'd0, w_s_carry};
        w_m_carry = (w_m_sum >= {1'b0, MINS_PER_HOUR});
        if (w_m_carry) begin
            w_m_sum = w_m_sum - {1'b0, MINS_PER_HOUR};
        end
        w_h_sum = w_m_carry ? (i_clock.hrs + 5'd1) : i_clock.hrs;
        if (w_h_sum > i_hour_mode) begin
            w_h_sum = w_h_sum - i_hour_mode;
        end
        w_snooze_clk.secs = w_s_sum[5:0];
        w_snooze_clk.mins = w_m_sum[5:0];
        w_snooze_clk.hrs  = w_h_sum;
    end

    // Button rules.
    always_comb begin
        w_mode    = i_mode;
        w_snooze  = i_snooze;
        w_cleared = 1'b0;
        unique case (i_buttons)
            BTN_SET_TIME: begin
                w_mode = MODE_SET_TIME;
            end
            BTN_SET_ALARM: begin
                w_mode = MODE_SET_ALARM;
            end
            BTN_ALARM: begin
                if (i_mode == MODE_SNOOZE || i_mode == MODE_ALARM) begin
                    w_mode    = MODE_DISP;
                    w_cleared = 1'b1;
                    w_snooze  = i_alarm;
                end else begin
                    w_mode = MODE_ALARM;
                end
            end
            default: begin
                if (i_mode == MODE_ALARM) begin
                    if (i_buttons != 3'b000) begin
                        w_mode = MODE_SNOOZE;
                    end
                    w_snooze = w_snooze_clk;
                end else begin
                    if (i_mode != MODE_SNOOZE) begin
                        w_mode = MODE_DISP;
                    end
                    w_cleared = 1'b1;
                end
            end
        endcase
        if (w_mode == MODE_ALARM) begin
            w_cleared = 1'b1;
        end
    end

    // Alarm or snooze time reached.
    assign w_match = (i_clock == i_alarm) || (i_clock == w_snooze);

    assign o_res.mode    = (w_mode != MODE_SET_ALARM && w_match) ? MODE_ALARM : w_mode;
    assign o_res.snooze  = w_snooze;
    assign o_res.cleared = w_cleared;
endmodule

// ===== src/alarm_clock_with_snooze.sv =====
// ----------------------------------------------------------------------------
// alarm_clock_with_snooze
// Time-of-day clock with alarm and snooze, driven by tick, control pass and
// time load transactions.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one operation per transaction: a tick, a control pass with
//   the latched buttons, a clock time load or an alarm time load. o_out
//   returns exactly one result per input transaction, in order: the mode,
//   the beeper drive, the shown hours and minutes, the clock seconds, the
//   AM/PM flag and the button latch clear request.
//   i_cfg_we writes i_cfg_wdata into the hour wrap limit (12 or 24); write
//   it only while no transaction is in flight.
//   A transaction accepted on i_in is held in the input register, and its
//   result is loaded into the output register once that register is free.
//   One transaction per cycle is sustained while the receiver takes results;
//   combinational logic between the two registers updates the clock state.
//   Reset sets the clock to 12:01:00 AM, the alarm and snooze times to
//   12:00:00, the mode to display and the hour limit to 12.
//   When the receiver stalls, the result waits in the output register, one
//   more transaction is taken into the input register, and then i_in.ready
//   drops until the result is taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module alarm_clock_with_snooze #(
    parameter int TICKS_PER_SECOND = 128
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [4:0] i_cfg_wdata,
    acw_in_if.sink     i_in,
    acw_out_if.source  o_out
);
    import acw_pkg::*;

    localparam int PW = $clog2(TICKS_PER_SECOND);

    // Pipeline registers.
    logic       r_in_valid;
    t_acw_in    r_in;
    logic       r_out_valid;
    t_acw_out   r_out;

    // Clock state.
    logic [4:0]    r_hour_mode;
    logic [PW-1:0] r_presc;
    logic [PW-1:0] n_presc;
    t_hms          r_clock;
    t_hms          n_clock;
    logic          r_half_day;
    logic          n_half_day;
    logic          r_beep;
    logic          n_beep;
    t_hms          r_alarm;
    t_hms          n_alarm;
    t_hms          r_snooze;
    t_hms          n_snooze;
    logic [2:0]    r_mode;
    logic [2:0]    n_mode;
    logic          n_cleared;
    t_acw_out      n_out;

    logic          w_adv;
    logic          w_in_acc;
    logic [PW-1:0] w_tick_presc;
    t_clk_state    w_tick_cur;
    t_clk_state    w_tick_nxt;
    logic          w_beep_toggle;
    t_ctrl_res     w_ctrl;

    // Handshake: the held transaction advances when the output register is free.
    assign w_adv       = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_in_valid || w_adv;
    assign w_in_acc    = i_in.valid && i_in.ready;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    // Tick and control pass logic.
    assign w_tick_cur.time_of_day = r_clock;
    assign w_tick_cur.half_day    = r_half_day;

    acw_tick #(
        .TICKS_PER_SECOND(TICKS_PER_SECOND)
    ) u_tick (
        .i_presc       (r_presc),
        .i_cur         (w_tick_cur),
        .i_hour_mode   (r_hour_mode),
        .o_presc       (w_tick_presc),
        .o_nxt         (w_tick_nxt),
        .o_beep_toggle (w_beep_toggle)
    );

    acw_ctrl u_ctrl (
        .i_mode      (r_mode),
        .i_buttons   (r_in.buttons),
        .i_clock     (r_clock),
        .i_alarm     (r_alarm),
        .i_snooze    (r_snooze),
        .i_hour_mode (r_hour_mode),
        .o_res       (w_ctrl)
    );

    // Next state by operation.
    always_comb begin
        n_presc    = r_presc;
        n_clock    = r_clock;
        n_half_day = r_half_day;
        n_beep     = r_beep;
        n_alarm    = r_alarm;
        n_snooze   = r_snooze;
        n_mode     = r_mode;
        n_cleared  = 1'b0;
        unique case (r_in.op)
            OP_TICK: begin
                n_presc    = w_tick_presc;
                n_clock    = w_tick_nxt.time_of_day;
                n_half_day = w_tick_nxt.half_day;
                n_beep     = r_beep ^ w_beep_toggle;
            end
            OP_CTRL: begin
                n_mode    = w_ctrl.mode;
                n_snooze  = w_ctrl.snooze;
                n_cleared = w_ctrl.cleared;
            end
            OP_LOAD_CLOCK: begin
                n_clock.hrs  = r_in.load_hours;
                n_clock.mins = r_in.load_minutes;
                n_clock.secs = r_in.load_seconds;
            end
            OP_LOAD_ALARM: begin
                n_alarm.hrs  = r_in.load_hours;
                n_alarm.mins = (r_in.load_minutes >= MINS_PER_HOUR) ? 6'd0 : r_in.load_minutes;
                n_alarm.secs = r_in.load_seconds;
            end
            default: begin
                n_mode = r_mode;
            end
        endcase
    end

    // Result formed from the updated state.
    always_comb begin
        n_out.mode            = n_mode;
        n_out.beeper_on       = (n_mode == MODE_ALARM) && n_beep;
        n_out.shown_hours     = (n_mode == MODE_SET_ALARM) ? n_alarm.hrs : n_clock.hrs;
        n_out.shown_minutes   = (n_mode == MODE_SET_ALARM) ? n_alarm.mins : n_clock.mins;
        n_out.clock_seconds   = n_clock.secs;
        n_out.pm_flag         = n_half_day;
        n_out.buttons_cleared = n_cleared;
    end

    // Control and clock state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_hour_mode  <= HOUR_MODE_RST;
            r_presc      <= '0;
            r_clock.hrs  <= CLK_HRS_RST;
            r_clock.mins <= CLK_MINS_RST;
            r_clock.secs <= '0;
            r_half_day   <= 1'b0;
            r_beep       <= 1'b0;
            r_alarm.hrs  <= CLK_HRS_RST;
            r_alarm.mins <= '0;
            r_alarm.secs <= '0;
            r_snooze.hrs  <= CLK_HRS_RST;
            r_snooze.mins <= '0;
            r_snooze.secs <= '0;
            r_mode       <= MODE_DISP;
        end else begin
            if (i_cfg_we) begin
                r_hour_mode <= i_cfg_wdata;
            end
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_adv) begin
                r_presc    <= n_presc;
                r_clock    <= n_clock;
                r_half_day <= n_half_day;
                r_beep     <= n_beep;
                r_alarm    <= n_alarm;
                r_snooze   <= n_snooze;
                r_mode     <= n_mode;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in <= i_in.data;
        end
        if (w_adv) begin
            r_out <= n_out;
        end
    end

    // Assertions.
    `ACW_ASSERT_NEXT(a_tick_norm, i_clk, i_rst_n, w_adv && r_in.op == OP_TICK,
        r_clock.secs < SECS_PER_MIN && r_clock.mins < MINS_PER_HOUR,
        "tick left the clock time out of range")
    `ACW_ASSERT_NEXT(a_clear_ctrl, i_clk, i_rst_n, w_adv && r_in.op != OP_CTRL,
        !r_out.buttons_cleared, "latch clear without a control pass")
    `ACW_ASSERT_SAME(a_show_alarm, i_clk, i_rst_n,
        r_out_valid && r_out.mode == MODE_SET_ALARM,
        r_out.shown_hours == r_alarm.hrs && r_out.shown_minutes == r_alarm.mins,
        "set-alarm result does not show the alarm time")
    `ACW_ASSERT_SAME(a_beep_mode, i_clk, i_rst_n, r_out_valid && r_out.beeper_on,
        r_out.mode == MODE_ALARM, "beeper driven outside alarm mode")
    `ACW_ASSERT_SAME(a_presc_range, i_clk, i_rst_n, 1'b1,
        ({1'b0, r_presc} < (PW + 1)'(TICKS_PER_SECOND)), "prescaler beyond one second")
endmodule
